[rtl/core/mtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front list and its cells.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // List values, lengths and costs never exceed the 9-bit length register
  localparam int VAL_W = 9;
  localparam int LEN_W = 9;
  localparam int SUM_W = 32;

  localparam int              DEF_MAX_ENTRIES = 256;
  localparam logic [LEN_W-1:0] LEN_RESET      = LEN_W'(256);
  localparam logic [SUM_W-1:0] SUM_MAX        = '1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  // Token handed from one cell to the next: the displaced value
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } token_t;

endpackage

[rtl/core/mtf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_cell
// One list entry. A passing token drops its value here and picks up the old
// one; the cell holding the key absorbs the token and ends the walk.
// ----------------------------------------------------------------------------
module mtf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      reload,
  input  logic [mtf_pkg::VAL_W-1:0] init_val,
  input  logic [mtf_pkg::VAL_W-1:0] key,
  input  mtf_pkg::token_t           tok_in,
  output mtf_pkg::token_t           tok_out,
  output logic                      hit
);
  import mtf_pkg::*;

  logic [VAL_W-1:0] val;
  logic             tok_vld;
  logic [VAL_W-1:0] tok_val;

  // key found in this entry while the token is here
  assign hit = tok_in.vld && (val == key);

  // entry value: reload to ascending order, or take the incoming carry
  always_ff @(posedge clk) begin
    if (reload) begin
      val <= init_val;
    end else if (tok_in.vld) begin
      val <= tok_in.val;
    end
  end

  // token moves on unless absorbed here
  always_ff @(posedge clk) begin
    if (rst || reload) begin
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= tok_in.vld && !hit;
    end
  end

  always_ff @(posedge clk) begin
    tok_val <= val;
  end

  assign tok_out.vld = tok_vld;
  assign tok_out.val = tok_val;

endmodule

[rtl/core/move_to_front_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_list
// Move-to-front self-organizing list built as a row of compare-and-swap cells.
// ----------------------------------------------------------------------------
// One request at a time. A value that is in the list sends a token down the
// cell row, one cell per clock, carrying each displaced value one place back
// until it reaches the cell holding the value, which ends ST_SEARCH; an absent
// value goes straight from ST_IDLE to ST_HOLD. A request leaves ST_HOLD only
// once the output register is free. A result waiting at the output does not
// stop the next request from being taken. Restarting the list (reset, a
// list_length write, or the end of a run) reloads every cell together.
module move_to_front_list #(
  parameter int MAX_ENTRIES = mtf_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  // config
  input  logic                      cfg_we,
  input  logic [mtf_pkg::LEN_W-1:0] cfg_wdata,
  // request
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mtf_pkg::VAL_W-1:0] access_value,
  input  logic                      last_of_run,
  // result
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mtf_pkg::VAL_W-1:0] access_cost,
  output logic                      found,
  output logic [mtf_pkg::SUM_W-1:0] total_cost
);
  import mtf_pkg::*;

  // clamp the length register to 1..MAX_ENTRIES
  function automatic logic [VAL_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [VAL_W-1:0] n;
    if (len == '0) begin
      n = VAL_W'(1);
    end else if (int'(len) > MAX_ENTRIES) begin
      n = VAL_W'(MAX_ENTRIES);
    end else begin
      n = VAL_W'(len);
    end
    return n;
  endfunction

  state_t state, state_next;

  logic [LEN_W-1:0] len, len_next;
  logic [VAL_W-1:0] n_cur, n_init;
  logic [VAL_W-1:0] key;
  logic             last_q;
  logic             launch;
  logic [VAL_W-1:0] cnt;
  logic [VAL_W-1:0] res_cost;
  logic             res_found;
  logic [SUM_W-1:0] sum;

  logic             accept, present, hit_any, hold_go, restart, reload, sum_upd;
  logic [VAL_W-1:0] cost_now;
  logic [SUM_W:0]   sum_wide;

  token_t                  tok     [0:MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  hit_vec;
  logic [VAL_W-1:0]        init_v  [0:MAX_ENTRIES-1];

  // length register
  always_comb begin
    if (rst) begin
      len_next = LEN_RESET;
    end else if (cfg_we) begin
      len_next = cfg_wdata;
    end else begin
      len_next = len;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
  end

  assign n_cur  = clamp_len(len);
  assign n_init = clamp_len(len_next);

  // handshake decode
  assign accept  = in_valid && in_ready;
  assign present = (access_value != '0) && (access_value <= n_cur);
  assign hit_any = |hit_vec;
  assign hold_go = (state == ST_HOLD) && (!out_valid || out_ready);
  assign restart = hold_go && last_q;
  assign reload  = rst || cfg_we || restart;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = present ? ST_SEARCH : ST_HOLD;
        end
      end
      ST_SEARCH: begin
        if (hit_any) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hold_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    sum_upd  = 1'b0;
    cost_now = VAL_W'(1);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        sum_upd  = in_valid && !present;
      end
      ST_SEARCH: begin
        sum_upd  = hit_any;
        cost_now = cnt + VAL_W'(1);
      end
      ST_HOLD: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and walk counter
  always_ff @(posedge clk) begin
    if (accept) begin
      key    <= access_value;
      last_q <= last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept && present;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (state == ST_SEARCH) begin
      cnt <= cnt + VAL_W'(1);
    end
  end

  // saturating running total
  assign sum_wide = {1'b0, sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, cost_now};

  always_ff @(posedge clk) begin
    if (rst || cfg_we || restart) begin
      sum <= '0;
    end else if (sum_upd) begin
      sum <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_upd) begin
      res_cost  <= cost_now;
      res_found <= (state == ST_SEARCH);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go) begin
      access_cost <= res_cost;
      found       <= res_found;
      total_cost  <= sum;
    end
  end

  // cell row
  assign tok[0].vld = launch;
  assign tok[0].val = key;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int IDX = i;

    assign init_v[i] = (int'(n_init) > IDX) ? VAL_W'(IDX + 1) : '0;

    mtf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .reload   (reload),
      .init_val (init_v[i]),
      .key      (key),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .hit      (hit_vec[i])
    );
  end

`ifndef SYNTHESIS
  // a token always finds its value before leaving the row
  a_tok_end: assert property (@(posedge clk) disable iff (rst)
    !tok[MAX_ENTRIES].vld)
    else $error("token ran off the end of the cell row");

  // values are distinct, so at most one cell matches
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  // the walk never passes the active length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (cnt < n_cur))
    else $error("search ran past the list length");

  // a match is seen only during a walk and ends it
  a_hit_walk: assert property (@(posedge clk) disable iff (rst)
    hit_any |-> (state == ST_SEARCH) ##1 (state == ST_HOLD))
    else $error("match outside a search");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the move-to-front list.
// ----------------------------------------------------------------------------
// A queue of requests, filled phase by phase, feeds a clocked driver. The
// driver tracks its own copy of the list order and the running total, and
// predicts the cost, found flag and total for every accepted request. A
// clocked monitor checks each result against the oldest prediction. The list
// length is changed only while the block is drained. Both sides idle in
// random bursts, except in the last phase and the phases with idle_pct zero.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES = mtf_pkg::DEF_MAX_ENTRIES;

  typedef struct packed {
    logic [mtf_pkg::VAL_W-1:0] value;
    logic                      last;
  } mtf_request_t;

  typedef struct packed {
    logic [mtf_pkg::VAL_W-1:0] cost;
    logic                      hit;
    logic [mtf_pkg::SUM_W-1:0] total;
  } mtf_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [mtf_pkg::LEN_W-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [mtf_pkg::VAL_W-1:0] access_value = '0;
  logic                      last_of_run = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [mtf_pkg::VAL_W-1:0] access_cost;
  logic                      found;
  logic [mtf_pkg::SUM_W-1:0] total_cost;

  // Stimulus and prediction state
  mtf_request_t              request_queue[$];
  mtf_result_t               pending_results[$];
  logic [mtf_pkg::VAL_W-1:0] list_order[ENTRIES];
  logic [mtf_pkg::SUM_W-1:0] run_total;
  int unsigned               active_len;
  int unsigned               idle_pct = 0;
  bit                        quiet = 1'b0;
  int unsigned               error_count = 0;
  int unsigned               send_gap = 0;
  int unsigned               stall_left = 0;

  always #5 clk = ~clk;

  move_to_front_list dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .access_value(access_value),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .access_cost (access_cost),
    .found       (found),
    .total_cost  (total_cost)
  );

  // Ascending list of the active length, total cleared
  function automatic void restart_order();
    for (int i = 0; i < ENTRIES; i++) begin
      list_order[i] = (i < active_len) ? mtf_pkg::VAL_W'(i + 1) : '0;
    end
    run_total = '0;
  endfunction

  // Length register write: zero acts as one, oversize clamps to the list size
  function automatic void apply_length(input logic [mtf_pkg::LEN_W-1:0] len);
    if (len == 0) begin
      active_len = 1;
    end else if (len > ENTRIES) begin
      active_len = ENTRIES;
    end else begin
      active_len = len;
    end
    restart_order();
  endfunction

  // Look up a value, move it to the front, and queue the expected result
  function automatic void predict_access(input logic [mtf_pkg::VAL_W-1:0] value,
                                         input logic last);
    int unsigned pos;
    int unsigned cost;
    bit          hit;
    mtf_result_t res;
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < active_len; i++) begin
      if (!hit && list_order[i] == value) begin
        hit = 1'b1;
        pos = i;
      end
    end
    cost = hit ? pos + 1 : 1;
    if (hit) begin
      for (int i = pos; i > 0; i--) list_order[i] = list_order[i-1];
      list_order[0] = value;
    end
    // saturating total
    if (longint'(run_total) + cost > longint'(mtf_pkg::SUM_MAX)) begin
      run_total = mtf_pkg::SUM_MAX;
    end else begin
      run_total = run_total + cost;
    end
    res.cost  = mtf_pkg::VAL_W'(cost);
    res.hit   = hit;
    res.total = run_total;
    pending_results.push_back(res);
    if (last) restart_order();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Request driver
  always @(posedge clk) begin : request_driver
    mtf_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_access(access_value, last_of_run);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          if (!quiet && $urandom_range(99) < idle_pct) begin
            send_gap = $urandom_range(8);
            in_valid <= 1'b0;
          end else begin
            req = request_queue.pop_front();
            access_value <= req.value;
            last_of_run  <= req.last;
            in_valid     <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : result_monitor
    mtf_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: cost %0d found %0b total %0d",
                   $time, access_cost, found, total_cost);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("access_cost", 32'(want.cost), 32'(access_cost));
          check_field("found", 32'(want.hit), 32'(found));
          check_field("total_cost", want.total, total_cost);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_request(input int unsigned value, input bit last);
    mtf_request_t req;
    req.value = mtf_pkg::VAL_W'(value);
    req.last  = last;
    request_queue.push_back(req);
  endtask

  // Block until every request is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  task automatic write_length(input int unsigned len);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wdata <= mtf_pkg::LEN_W'(len);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_length(mtf_pkg::LEN_W'(len));
    @(negedge clk);
  endtask

  // Mostly valid values with a hot set near the front, some noise
  task automatic queue_random_request();
    int unsigned roll;
    int unsigned value;
    int unsigned hot_top;
    roll    = $urandom_range(99);
    hot_top = (active_len < 8) ? active_len : 8;
    if (roll < 15) begin
      value = $urandom_range(511);
    end else if (roll < 55) begin
      value = $urandom_range(hot_top, 1);
    end else begin
      value = $urandom_range(active_len, 1);
    end
    queue_request(value, $urandom_range(19) == 0);
  endtask

  initial begin : stimulus
    int unsigned len;
    apply_length(mtf_pkg::LEN_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: front hit, deepest entry, absent values, end of run
    idle_pct = 20;
    queue_request(1, 0);
    queue_request(256, 0);
    queue_request(256, 0);
    queue_request(0, 0);
    queue_request(257, 0);
    queue_request(511, 0);
    queue_request(128, 1);
    queue_request(128, 0);
    queue_request(1, 0);
    // single-entry list
    write_length(1);
    queue_request(1, 0);
    queue_request(2, 0);
    queue_request(1, 1);
    // zero length acts as one
    write_length(0);
    queue_request(1, 0);
    queue_request(0, 0);
    // oversize lengths clamp to the full list
    write_length(511);
    queue_request(256, 0);
    queue_request(255, 0);
    write_length(257);
    queue_request(170, 0);
    queue_request(85, 0);
    write_length(2);
    queue_request(2, 0);
    queue_request(2, 0);
    queue_request(1, 0);
    queue_request(3, 1);

    // Random phases over a spread of lengths; each boundary drains the block
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: len = $urandom_range(8, 2);
        1: len = $urandom_range(64, 9);
        2: len = ENTRIES;
        3: len = $urandom_range(16, 2);
        4: len = $urandom_range(511, 257);
        5: len = $urandom_range(255, 65);
        6: len = $urandom_range(4, 1);
        default: len = $urandom_range(32, 2);
      endcase
      write_length(len);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 35;
      endcase
      if (ph == 7) quiet = 1'b1;
      repeat (50) queue_random_request();
    end

    wait_drained();
    // allow for a late stray result: deepest search plus margin
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("[move_to_front_list] OK");
    end else begin
      $display("[move_to_front_list] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("[move_to_front_list] ERROR");
    $finish;
  end

endmodule
